// File: design/irp_pkg.sv
// Package for the int4 weight repacker: shared types, codes and conversion functions.
// Used by every module of the repacker; depends on nothing.
package irp_pkg;

    localparam int CFG_W   = 15;
    localparam int IDX_W   = 14;
    localparam int ADDR_W  = 29;
    localparam int VALUE_W = 32;

    localparam logic [31:0] XOR_MASK = 32'h8888_8888;

    typedef enum logic [2:0] {
        OP_GATE_WORD  = 3'd0,
        OP_UP_WORD    = 3'd1,
        OP_DOWN_WORD  = 3'd2,
        OP_GATE_SCALE = 3'd3,
        OP_UP_SCALE   = 3'd4,
        OP_DOWN_SCALE = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ARR_GU_WEIGHT = 2'd0,
        ARR_GU_SCALE  = 2'd1,
        ARR_DN_WEIGHT = 2'd2,
        ARR_DN_SCALE  = 2'd3
    } arr_t;

    typedef enum logic [1:0] {
        CFG_HIDDEN       = 2'd0,
        CFG_INTERMEDIATE = 2'd1,
        CFG_GROUP        = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic busy;
        logic ok;
    } size_status_t;

    typedef struct packed {
        logic [1:0]         arr;
        logic               up;
        logic               rejected;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [VALUE_W-1:0] value;
    } entry_t;

    function automatic logic [31:0] permute_nibbles(input logic [31:0] w);
        logic [31:0] r;
        r = {w[31:28], w[15:12], w[27:24], w[11:8], w[23:20], w[7:4], w[19:16], w[3:0]};
        return r;
    endfunction

    function automatic logic [15:0] to_half(input logic [31:0] x);
        logic [15:0] sgn;
        logic [7:0]  ex;
        logic [22:0] man;
        logic [23:0] m;
        logic [6:0]  sh;
        logic [23:0] q;
        logic [23:0] rem;
        logic [23:0] hb;
        logic [15:0] qn;
        logic [12:0] remn;
        logic [15:0] r;
        sgn  = {x[31], 15'd0};
        ex   = x[30:23];
        man  = x[22:0];
        m    = {1'b1, man};
        sh   = 7'd126 - {1'b0, 6'd0} - 7'(ex);
        q    = m >> sh;
        rem  = m & ((24'd1 << sh) - 24'd1);
        hb   = 24'd1 << (sh - 7'd1);
        qn   = {1'b0, 5'(ex - 8'd112), man[22:13]};
        remn = man[12:0];
        if (ex == 8'hff) begin
            if (man != 23'd0) begin
                r = sgn | 16'h7e00 | {6'd0, man[22:13]};
            end
            else begin
                r = sgn | 16'h7c00;
            end
        end
        else if (ex == 8'd0) begin
            r = sgn;
        end
        else if (ex >= 8'd143) begin
            r = sgn | 16'h7c00;
        end
        else if (ex <= 8'd112) begin
            if (sh > 7'd24) begin
                r = sgn;
            end
            else begin
                if (rem > hb || (rem == hb && q[0])) begin
                    q = q + 24'd1;
                end
                r = sgn | q[15:0];
            end
        end
        else begin
            if (remn > 13'h1000 || (remn == 13'h1000 && qn[0])) begin
                qn = qn + 16'd1;
            end
            r = sgn | qn;
        end
        return r;
    endfunction

endpackage

// File: design/irp_size_check.sv
// Size registers and their validity check for the int4 weight repacker.
// Remainders by the group size are found one bit per cycle; depends on irp_pkg.
module irp_size_check #(
    parameter int MAX_DIM = 16384
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [irp_pkg::CFG_W-1:0] cfg_data,
    output logic [irp_pkg::CFG_W-1:0] hidden,
    output logic [irp_pkg::CFG_W-1:0] inter,
    output logic [irp_pkg::CFG_W-1:0] group,
    output irp_pkg::size_status_t    status
);
    import irp_pkg::*;

    logic [CFG_W-1:0] h_reg, i_reg, g_reg;
    logic [CFG_W:0]   rh_reg, ri_reg, rh_next, ri_next, rh_sh, ri_sh;
    logic [3:0]       cnt_reg;
    logic             busy_reg, ok_reg;
    logic             static_ok;

    localparam logic [16:0] MAX_D = 17'(MAX_DIM);

    assign static_ok = h_reg != '0 && i_reg != '0 && g_reg != '0
        && {2'd0, h_reg} <= MAX_D && {2'd0, i_reg} <= MAX_D && {2'd0, g_reg} <= MAX_D
        && !h_reg[0] && !i_reg[0];

    always_comb
    begin
        rh_sh   = {rh_reg[CFG_W-1:0], h_reg[4'(CFG_W-1) - cnt_reg]};
        ri_sh   = {ri_reg[CFG_W-1:0], i_reg[4'(CFG_W-1) - cnt_reg]};
        rh_next = (rh_sh >= {1'b0, g_reg}) ? rh_sh - {1'b0, g_reg} : rh_sh;
        ri_next = (ri_sh >= {1'b0, g_reg}) ? ri_sh - {1'b0, g_reg} : ri_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg    <= 15'd4096;
            i_reg    <= 15'd1024;
            g_reg    <= 15'd128;
            busy_reg <= 1'b0;
            ok_reg   <= 1'b1;
            cnt_reg  <= '0;
            rh_reg   <= '0;
            ri_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HIDDEN:       h_reg <= cfg_data;
                CFG_INTERMEDIATE: i_reg <= cfg_data;
                CFG_GROUP:        g_reg <= cfg_data;
                default:          ;
            endcase
            busy_reg <= 1'b1;
            ok_reg   <= 1'b0;
            cnt_reg  <= '0;
            rh_reg   <= '0;
            ri_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rh_reg  <= rh_next;
            ri_reg  <= ri_next;
            cnt_reg <= cnt_reg + 4'd1;
            if (cnt_reg == 4'(CFG_W-1))
            begin
                busy_reg <= 1'b0;
                ok_reg   <= static_ok && rh_next == '0 && ri_next == '0;
            end
        end
    end

    assign hidden      = h_reg;
    assign inter       = i_reg;
    assign group       = g_reg;
    assign status.busy = busy_reg;
    assign status.ok   = ok_reg;

endmodule

// File: design/irp_front.sv
// Front part of the int4 weight repacker: decodes the operation and checks ranges.
// Produces one queue entry per accepted word; depends on irp_pkg.
module irp_front (
    input  logic [2:0]                 operation,
    input  logic [irp_pkg::IDX_W-1:0]  row_index,
    input  logic [irp_pkg::IDX_W-1:0]  column_index,
    input  logic [31:0]                source_value,
    input  logic [irp_pkg::CFG_W-1:0]  hidden,
    input  logic [irp_pkg::CFG_W-1:0]  inter,
    input  logic [irp_pkg::CFG_W-1:0]  group,
    input  logic                       sizes_ok,
    output irp_pkg::entry_t            entry
);
    import irp_pkg::*;

    logic [CFG_W-1:0] rows, len;
    logic [28:0]      prod;
    logic             is_gu, is_scale, col_ok;

    always_comb
    begin
        is_gu    = 1'b0;
        is_scale = 1'b0;
        unique case (operation)
            OP_GATE_WORD, OP_UP_WORD:   is_gu = 1'b1;
            OP_GATE_SCALE, OP_UP_SCALE:
            begin
                is_gu    = 1'b1;
                is_scale = 1'b1;
            end
            OP_DOWN_SCALE:              is_scale = 1'b1;
            default:                    ;
        endcase
        rows   = is_gu ? inter : hidden;
        len    = is_gu ? hidden : inter;
        prod   = 29'(column_index) * 29'(group);
        col_ok = is_scale ? (prod < 29'(len)) : ({1'b0, column_index} < (len >> 3));

        entry.rejected = operation > OP_DOWN_SCALE || !sizes_ok
            || {1'b0, row_index} >= rows || !col_ok;
        entry.up    = operation == OP_UP_WORD || operation == OP_UP_SCALE;
        entry.arr   = {!is_gu, is_scale};
        entry.row   = row_index;
        entry.col   = column_index;
        entry.value = source_value;
    end

endmodule

// File: design/irp_fifo.sv
// Short queue between the front and back parts of the int4 weight repacker.
// Four entries of irp_pkg::entry_t; depends on irp_pkg.
module irp_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  irp_pkg::entry_t wr_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output irp_pkg::entry_t rd_data
);
    import irp_pkg::*;

    entry_t     mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 2'd1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end

    assign full      = cnt_reg == 3'd4;
    assign not_empty = cnt_reg != 3'd0;
    assign rd_data   = mem_reg[rp_reg];

endmodule

// File: design/irp_back.sv
// Back part of the int4 weight repacker: address arithmetic, nibble shuffle, half conversion.
// Holds the output register; depends on irp_pkg.
module irp_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  irp_pkg::entry_t           q_data,
    output logic                      q_pop,
    input  logic [irp_pkg::CFG_W-1:0] hidden,
    input  logic [irp_pkg::CFG_W-1:0] inter,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                out_array,
    output logic [irp_pkg::ADDR_W-1:0] out_address,
    output logic [31:0]               out_value,
    output logic                      out_rejected
);
    import irp_pkg::*;

    logic [15:0]       stride, base;
    logic [29:0]       prod;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       res;
    logic              valid_reg;
    logic [1:0]        arr_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [31:0]       val_reg;
    logic              rej_reg;

    always_comb
    begin
        stride = q_data.arr[1] ? {1'b0, hidden} : {inter, 1'b0};
        base   = q_data.up ? {1'b0, inter} : 16'd0;
        prod   = 30'(q_data.col) * 30'(stride);
        addr   = ADDR_W'(prod + 30'(base) + 30'(q_data.row));
        res    = q_data.arr[0] ? {16'd0, to_half(q_data.value)}
                               : permute_nibbles(q_data.value ^ XOR_MASK);
    end

    assign q_pop = q_valid && (!valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rej_reg  <= q_data.rejected;
            arr_reg  <= q_data.rejected ? 2'd0 : q_data.arr;
            addr_reg <= q_data.rejected ? '0 : addr;
            val_reg  <= q_data.rejected ? '0 : res;
        end
    end

    assign out_valid    = valid_reg;
    assign out_array    = arr_reg;
    assign out_address  = addr_reg;
    assign out_value    = val_reg;
    assign out_rejected = rej_reg;

endmodule

// File: design/int4_weight_repacker_unit.sv
// Top level of the int4 weight repacker: size check, front, queue and back.
// Depends on irp_pkg, irp_size_check, irp_front, irp_fifo and irp_back.
//
// Usage: each slave-side word is one source element, either a packed word of
// eight signed 4-bit weights or a float32 scale, selected by the operation in
// s_axis_tuser. Each accepted word yields exactly one master-side word holding
// the target array, the transposed address and the repacked value, with
// m_axis_tuser set when the element is rejected. Words flow at one per cycle
// while the queue has room and no size check runs; each passes the queue write
// and then the output register before m_axis_tvalid. A four-word queue
// separates the front and the back, so s_axis_tready stays high while the
// receiver stalls until the queue fills. A configuration write starts a size
// check, one remainder bit per cycle; s_axis_tready is low during it. Reset
// loads the default sizes, which are valid, so words are taken right after it.
module int4_weight_repacker_unit #(
    parameter int MAX_DIM = 16384
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // row_index, column_index, source_value
    input  logic [2:0]  s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // target_array, target_address, result_value
    output logic        m_axis_tuser,  // rejected
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data
);
    import irp_pkg::*;

    logic [CFG_W-1:0]  hidden, inter, group;
    size_status_t      status;
    entry_t            f_entry, q_entry;
    logic              q_full, q_valid, q_pop, push;
    logic [1:0]        o_arr;
    logic [ADDR_W-1:0] o_addr;
    logic [31:0]       o_val;

    irp_size_check #(.MAX_DIM(MAX_DIM)) u_size (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .hidden(hidden), .inter(inter), .group(group),
        .status(status)
    );

    irp_front u_front (
        .operation(s_axis_tuser), .row_index(s_axis_tdata[13:0]),
        .column_index(s_axis_tdata[27:14]), .source_value(s_axis_tdata[59:28]),
        .hidden(hidden), .inter(inter), .group(group), .sizes_ok(status.ok),
        .entry(f_entry)
    );

    assign s_axis_tready = !q_full && !status.busy;
    assign push          = s_axis_tvalid && s_axis_tready;

    irp_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .push(push), .wr_data(f_entry), .full(q_full),
        .pop(q_pop), .not_empty(q_valid), .rd_data(q_entry)
    );

    irp_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_entry), .q_pop(q_pop),
        .hidden(hidden), .inter(inter), .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready), .out_array(o_arr), .out_address(o_addr),
        .out_value(o_val), .out_rejected(m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, o_val, o_addr, o_arr};

    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !s_axis_tready)
        else $error("input accepted during size check");

    a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 64'd0)
        else $error("rejected word carries data");

    a_half_upper: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[62:47] == 16'd0)
        else $error("scale result has upper bits set");

endmodule
